@@ rtl/sbic_pkg.sv @@
// sbic_pkg: shared types and codes for the store buffer issue control block
// request payloads, result payloads, front-to-back command and sequencer states
// no dependencies
package sbic_pkg;

    // input opcodes
    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_TICK     = 2'd2,
        OP_UNUSED   = 2'd3
    } opcode_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_STORE_NOTICE  = 3'd0,
        KIND_PREFETCH      = 3'd1,
        KIND_ISSUE         = 3'd2,
        KIND_ATOMIC_NOTICE = 3'd3,
        KIND_DEADLOCK      = 3'd4,
        KIND_ERROR         = 3'd5
    } kind_t;

    // configuration register index (word address bit)
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic [31:0] THRESHOLD_RESET = 32'd500000;

    typedef struct packed {
        opcode_t       opcode;
        logic [47:0]   address;
        logic [6:0]    access_size;
        logic          is_atomic;
        logic [7:0]    thread_id;
        logic [47:0]   program_counter;
        logic          priv_mode;
    } item_t;

    typedef struct packed {
        kind_t         kind;
        logic [47:0]   out_address;
        logic [6:0]    out_size;
        logic          out_atomic;
        logic [7:0]    out_thread;
        logic [47:0]   out_pc;
        logic          out_mode;
        logic          ready_res;
        logic          last;
    } result_t;

    // per-entry side information
    typedef struct packed {
        logic [6:0]    size;
        logic          atomic;
        logic [7:0]    thread;
        logic          mode;
    } info_t;

    typedef struct packed {
        logic [47:0]   address;
        logic [47:0]   pc;
        info_t         info;
        logic [31:0]   stamp;
    } entry_t;

    // classified request from front to back
    typedef struct packed {
        opcode_t       op;
        logic [47:0]   address;
        logic [47:0]   pc;
        info_t         info;
        logic          line_aligned;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_FETCH = 2'd1,
        BK_LOAD  = 2'd2,
        BK_EMIT  = 2'd3
    } back_state_t;

endpackage

@@ rtl/store_buffer_issue_control.sv @@
// store buffer issue control, top level: total store order store buffer fifo
// result path: command queue, back-end result registers, result queue; a retire that reissues
//   first passes the fetch and load states; the back end takes one request at a time and
//   emits each of its results before it takes the next
// reset: rst_n async active low clears pointers, counts, flags, time; threshold to 500000
// depends on sbic_pkg, sbic_fifo, sbic_front, sbic_back
module store_buffer_issue_control #(
    parameter int DEPTH      = 128,
    parameter int LINE_BYTES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    // request side
    input  logic               push,
    output logic               full,
    input  sbic_pkg::item_t    item,
    // result side
    input  logic               pop,
    output logic               empty,
    output sbic_pkg::result_t  result,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // queue between front and back, and the result queue
    localparam int QDEPTH = 2;
    localparam int CMD_W  = $bits(sbic_pkg::cmd_t);
    localparam int RES_W  = $bits(sbic_pkg::result_t);

    logic [31:0]       threshold_reg, threshold_next;
    logic              cfg_write;

    logic              cq_push, cq_full, cq_empty, cq_pop;
    sbic_pkg::cmd_t    cq_wcmd, cq_rcmd;
    logic [CMD_W-1:0]  cq_rdata;

    logic              rq_push, rq_full;
    sbic_pkg::result_t rq_wdata;
    logic [RES_W-1:0]  rq_rdata;

    // configuration: single register at word 0, byte offset ignored
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == sbic_pkg::REG_THRESHOLD);
    assign prdata    = (paddr[2] == sbic_pkg::REG_THRESHOLD) ? threshold_reg : 32'd0;

    always_comb
    begin
        threshold_next = threshold_reg;
        if (cfg_write)
        begin
            threshold_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= sbic_pkg::THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    // front: takes requests while the command queue has room
    sbic_front #(
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .push   (push),
        .item   (item),
        .full   (full),
        .q_full (cq_full),
        .q_push (cq_push),
        .q_cmd  (cq_wcmd)
    );

    // decoupling queue: front keeps accepting while the back end works
    sbic_fifo #(
        .WIDTH  (CMD_W),
        .QDEPTH (QDEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cq_push),
        .wdata (cq_wcmd),
        .full  (cq_full),
        .pop   (cq_pop),
        .rdata (cq_rdata),
        .empty (cq_empty)
    );

    assign cq_rcmd = cq_rdata;

    // back: buffer state, entry memory, sequencing of results
    sbic_back #(
        .DEPTH      (DEPTH),
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cq_empty),
        .cmd       (cq_rcmd),
        .cmd_pop   (cq_pop),
        .out_push  (rq_push),
        .out_data  (rq_wdata),
        .out_full  (rq_full),
        .threshold (threshold_reg)
    );

    // result queue: back end goes on while a result waits to be popped
    sbic_fifo #(
        .WIDTH  (RES_W),
        .QDEPTH (QDEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .wdata (rq_wdata),
        .full  (rq_full),
        .pop   (pop),
        .rdata (rq_rdata),
        .empty (empty)
    );

    assign result = rq_rdata;

endmodule

@@ rtl/sbic_fifo.sv @@
// sbic_fifo: small register queue used between front and back and on the result side
// plain vector payload, push/full and pop/empty
// no package dependencies
module sbic_fifo #(
    parameter int WIDTH  = 8,
    parameter int QDEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/sbic_front.sv @@
// sbic_front: accepts requests and classifies them into back-end commands
// packs entry side information and checks line alignment
// depends on sbic_pkg
module sbic_front #(
    parameter int LINE_BYTES = 64
) (
    input  logic            push,
    input  sbic_pkg::item_t item,
    output logic            full,
    input  logic            q_full,
    output logic            q_push,
    output sbic_pkg::cmd_t  q_cmd
);

    // line size is a power of two
    localparam int LINE_SHIFT = $clog2(LINE_BYTES);

    assign full   = q_full;
    assign q_push = push && !q_full;

    always_comb
    begin
        q_cmd.op           = item.opcode;
        q_cmd.address      = item.address;
        q_cmd.pc           = item.program_counter;
        q_cmd.info.size    = item.access_size;
        q_cmd.info.atomic  = item.is_atomic;
        q_cmd.info.thread  = item.thread_id;
        q_cmd.info.mode    = item.priv_mode;
        q_cmd.line_aligned = (item.address[LINE_SHIFT-1:0] == '0);
    end

endmodule

@@ rtl/sbic_back.sv @@
// sbic_back: store buffer state, entry memory and result sequencer
// executes one classified command at a time and emits up to two results
// depends on sbic_pkg
module sbic_back #(
    parameter int DEPTH      = 128,
    parameter int LINE_BYTES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  sbic_pkg::cmd_t     cmd,
    output logic               cmd_pop,
    output logic               out_push,
    output sbic_pkg::result_t  out_data,
    input  logic               out_full,
    input  logic [31:0]        threshold
);

    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int LINE_SHIFT = $clog2(LINE_BYTES);

    sbic_pkg::entry_t      entry_mem [DEPTH];
    sbic_pkg::entry_t      rd_reg;
    sbic_pkg::entry_t      head_reg;
    sbic_pkg::entry_t      wr_entry;

    sbic_pkg::back_state_t state_reg, state_next;
    logic [IDX_W-1:0]      head_idx_reg, head_idx_next;
    logic [IDX_W-1:0]      tail_idx_reg, tail_idx_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic                  pending_reg, pending_next;
    logic                  atomic_reg, atomic_next;
    logic [31:0]           time_reg, time_next;
    logic                  alarm_reg, alarm_next;

    sbic_pkg::result_t     res0_reg, res0_next;
    sbic_pkg::result_t     res1_reg, res1_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic                  emit_reg, emit_next;
    logic                  ready_reg, ready_next;

    logic                  mem_we;
    logic                  head_from_cmd;
    logic                  need_fetch;
    logic                  emit_last;
    logic [1:0]            n;
    sbic_pkg::result_t     r0, r1, issue_r;
    logic [31:0]           time_plus;
    logic [31:0]           age;

    function automatic sbic_pkg::result_t mk_result(sbic_pkg::kind_t k, logic [47:0] a,
                                                    sbic_pkg::info_t i, logic [47:0] p);
        sbic_pkg::result_t r;
        r.kind        = k;
        r.out_address = a;
        r.out_size    = i.size;
        r.out_atomic  = i.atomic;
        r.out_thread  = i.thread;
        r.out_pc      = p;
        r.out_mode    = i.mode;
        r.ready_res   = 1'b0;
        r.last        = 1'b0;
        return r;
    endfunction

    // entry built from an insert command
    always_comb
    begin
        wr_entry.address = cmd.address;
        wr_entry.pc      = cmd.pc;
        wr_entry.info    = cmd.info;
        wr_entry.stamp   = time_reg;
    end

    assign time_plus = time_reg + 32'd1;
    assign age       = time_plus - head_reg.stamp;
    assign emit_last = ({1'b0, emit_reg} + 2'd1) == cnt_reg;

    always_comb
    begin
        state_next    = state_reg;
        head_idx_next = head_idx_reg;
        tail_idx_next = tail_idx_reg;
        occ_next      = occ_reg;
        pending_next  = pending_reg;
        atomic_next   = atomic_reg;
        time_next     = time_reg;
        alarm_next    = alarm_reg;
        res0_next     = res0_reg;
        res1_next     = res1_reg;
        cnt_next      = cnt_reg;
        emit_next     = emit_reg;
        ready_next    = ready_reg;
        cmd_pop       = 1'b0;
        mem_we        = 1'b0;
        head_from_cmd = 1'b0;
        need_fetch    = 1'b0;
        out_push      = 1'b0;
        out_data      = emit_reg ? res1_reg : res0_reg;
        out_data.ready_res = ready_reg;
        out_data.last      = emit_last;
        n       = 2'd0;
        r0      = mk_result(sbic_pkg::KIND_ERROR, '0, '0, '0);
        r1      = r0;
        issue_r = mk_result(sbic_pkg::KIND_ISSUE, rd_reg.address, rd_reg.info, rd_reg.pc);

        case (state_reg)
            sbic_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        sbic_pkg::OP_INSERT:
                        begin
                            if ((occ_reg == CNT_W'(DEPTH)) || atomic_reg)
                            begin
                                r0 = mk_result(sbic_pkg::KIND_ERROR, cmd.address,
                                               cmd.info, cmd.pc);
                                n  = 2'd1;
                            end
                            else
                            begin
                                if (!cmd.info.atomic)
                                begin
                                    r0 = mk_result(sbic_pkg::KIND_STORE_NOTICE, cmd.address,
                                                   cmd.info, cmd.pc);
                                    n  = 2'd1;
                                end
                                if (occ_reg != '0)
                                begin
                                    if (n == 2'd0)
                                    begin
                                        r0 = mk_result(sbic_pkg::KIND_PREFETCH, cmd.address,
                                                       cmd.info, cmd.pc);
                                    end
                                    else
                                    begin
                                        r1 = mk_result(sbic_pkg::KIND_PREFETCH, cmd.address,
                                                       cmd.info, cmd.pc);
                                    end
                                    n = n + 2'd1;
                                end
                                mem_we        = 1'b1;
                                occ_next      = occ_reg + 1'b1;
                                tail_idx_next = (tail_idx_reg == IDX_W'(DEPTH - 1)) ?
                                                '0 : tail_idx_reg + 1'b1;
                                if (cmd.info.atomic)
                                begin
                                    atomic_next = 1'b1;
                                end
                                if (occ_reg == '0)
                                begin
                                    head_from_cmd = 1'b1;
                                end
                                if ((n != 2'd2) && !pending_reg)
                                begin
                                    pending_next = 1'b1;
                                    // an empty buffer issues the new entry itself
                                    issue_r = (occ_reg == '0) ?
                                        mk_result(sbic_pkg::KIND_ISSUE, cmd.address,
                                                  cmd.info, cmd.pc) :
                                        mk_result(sbic_pkg::KIND_ISSUE, head_reg.address,
                                                  head_reg.info, head_reg.pc);
                                    if (n == 2'd0)
                                    begin
                                        r0 = issue_r;
                                    end
                                    else
                                    begin
                                        r1 = issue_r;
                                    end
                                    n = n + 2'd1;
                                end
                            end
                        end
                        sbic_pkg::OP_COMPLETE:
                        begin
                            if ((occ_reg == '0) || !pending_reg || !cmd.line_aligned ||
                                (head_reg.address[47:LINE_SHIFT] != cmd.address[47:LINE_SHIFT]))
                            begin
                                r0 = mk_result(sbic_pkg::KIND_ERROR, cmd.address, '0, '0);
                                n  = 2'd1;
                            end
                            else
                            begin
                                pending_next = 1'b0;
                                if (head_reg.info.atomic)
                                begin
                                    r0 = mk_result(sbic_pkg::KIND_ATOMIC_NOTICE,
                                                   head_reg.address, head_reg.info,
                                                   head_reg.pc);
                                    n  = 2'd1;
                                    atomic_next = 1'b0;
                                end
                                occ_next      = occ_reg - 1'b1;
                                head_idx_next = (head_idx_reg == IDX_W'(DEPTH - 1)) ?
                                                '0 : head_idx_reg + 1'b1;
                                alarm_next    = 1'b0;
                                // next head comes out of the entry memory
                                if (occ_reg != CNT_W'(1))
                                begin
                                    need_fetch   = 1'b1;
                                    pending_next = 1'b1;
                                end
                            end
                        end
                        sbic_pkg::OP_TICK:
                        begin
                            time_next = time_plus;
                            if ((occ_reg != '0) && !alarm_reg && (age >= threshold))
                            begin
                                alarm_next = 1'b1;
                                r0 = mk_result(sbic_pkg::KIND_DEADLOCK, head_reg.address,
                                               head_reg.info, head_reg.pc);
                                n  = 2'd1;
                            end
                        end
                        default:
                        begin
                            r0 = mk_result(sbic_pkg::KIND_ERROR, '0, '0, '0);
                            n  = 2'd1;
                        end
                    endcase
                    res0_next  = r0;
                    res1_next  = r1;
                    cnt_next   = n;
                    emit_next  = 1'b0;
                    ready_next = (occ_next != CNT_W'(DEPTH)) && !atomic_next;
                    if (need_fetch)
                    begin
                        state_next = sbic_pkg::BK_FETCH;
                    end
                    else if (n != 2'd0)
                    begin
                        state_next = sbic_pkg::BK_EMIT;
                    end
                end
            end
            sbic_pkg::BK_FETCH:
            begin
                state_next = sbic_pkg::BK_LOAD;
            end
            sbic_pkg::BK_LOAD:
            begin
                if (cnt_reg == 2'd0)
                begin
                    res0_next = issue_r;
                end
                else
                begin
                    res1_next = issue_r;
                end
                cnt_next   = cnt_reg + 2'd1;
                state_next = sbic_pkg::BK_EMIT;
            end
            sbic_pkg::BK_EMIT:
            begin
                out_push = 1'b1;
                if (!out_full)
                begin
                    if (emit_last)
                    begin
                        emit_next  = 1'b0;
                        state_next = sbic_pkg::BK_IDLE;
                    end
                    else
                    begin
                        emit_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = sbic_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sbic_pkg::BK_IDLE;
            head_idx_reg <= '0;
            tail_idx_reg <= '0;
            occ_reg      <= '0;
            pending_reg  <= 1'b0;
            atomic_reg   <= 1'b0;
            time_reg     <= '0;
            alarm_reg    <= 1'b0;
            cnt_reg      <= '0;
            emit_reg     <= 1'b0;
            ready_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_idx_reg <= head_idx_next;
            tail_idx_reg <= tail_idx_next;
            occ_reg      <= occ_next;
            pending_reg  <= pending_next;
            atomic_reg   <= atomic_next;
            time_reg     <= time_next;
            alarm_reg    <= alarm_next;
            cnt_reg      <= cnt_next;
            emit_reg     <= emit_next;
            ready_reg    <= ready_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res0_reg <= res0_next;
        res1_reg <= res1_next;
        if (head_from_cmd)
        begin
            head_reg <= wr_entry;
        end
        else if (state_reg == sbic_pkg::BK_LOAD)
        begin
            head_reg <= rd_reg;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[tail_idx_reg] <= wr_entry;
        end
        if (state_reg == sbic_pkg::BK_FETCH)
        begin
            rd_reg <= entry_mem[head_idx_reg];
        end
    end

endmodule

@@ rtl/sbic_checker.sv @@
// sbic_checker: port-level assertions for store_buffer_issue_control
// bound to the top level; depends on sbic_pkg
module sbic_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              pop,
    input logic              empty,
    input sbic_pkg::result_t result
);

    // result queue is empty while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty in reset");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed");

    // errors and deadlock alarms are always the last result of their request
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == sbic_pkg::KIND_ERROR ||
                    result.kind == sbic_pkg::KIND_DEADLOCK)) |-> result.last)
        else $error("error or alarm not final result");

    // notices agree with the entry's atomic flag
    a_notice: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == sbic_pkg::KIND_STORE_NOTICE)) |-> !result.out_atomic)
        else $error("store notice for atomic entry");

    a_atomic_notice: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == sbic_pkg::KIND_ATOMIC_NOTICE)) |-> result.out_atomic)
        else $error("atomic notice for plain entry");

endmodule

bind store_buffer_issue_control sbic_checker u_sbic_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking bench for the store buffer issue control block
// keeps its own copy of the buffer, predicts each result in order and checks it field by field
// depends on sbic_pkg and store_buffer_issue_control
module tb_top;

    localparam int BUF_DEPTH     = 128;
    localparam int LINE_SIZE     = 64;
    localparam int HALF_PERIOD   = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int IDLE_PCT      = 22;
    localparam logic [2:0] THRESHOLD_ADDR = {sbic_pkg::REG_THRESHOLD, 2'b00};

    // shadow of the store buffer plus the queue of results still owed by the block
    class issue_scoreboard;
        logic [47:0]        slot_addr [BUF_DEPTH];
        logic [47:0]        slot_pc [BUF_DEPTH];
        sbic_pkg::info_t    slot_info [BUF_DEPTH];
        logic [31:0]        slot_stamp [BUF_DEPTH];
        int unsigned        head;
        int unsigned        tail;
        int unsigned        count;
        bit                 issued;
        bit                 atomic_block;
        bit                 alarm_on;
        logic [31:0]        now;
        logic [31:0]        threshold;
        sbic_pkg::result_t  step_results[$];
        sbic_pkg::result_t  awaited[$];
        int                 error_count;

        function new();
            head         = 0;
            tail         = 0;
            count        = 0;
            issued       = 1'b0;
            atomic_block = 1'b0;
            alarm_on     = 1'b0;
            now          = '0;
            threshold    = sbic_pkg::THRESHOLD_RESET;
            error_count  = 0;
        endfunction

        // line the head entry belongs to, only meaningful while the buffer holds entries
        function logic [47:0] head_line();
            return slot_addr[head] - (slot_addr[head] % LINE_SIZE);
        endfunction

        function void emit(sbic_pkg::kind_t k, logic [47:0] addr, sbic_pkg::info_t inf,
                           logic [47:0] pc);
            sbic_pkg::result_t r;
            r.kind        = k;
            r.out_address = addr;
            r.out_size    = inf.size;
            r.out_atomic  = inf.atomic;
            r.out_thread  = inf.thread;
            r.out_pc      = pc;
            r.out_mode    = inf.mode;
            r.ready_res   = 1'b0;
            r.last        = 1'b0;
            step_results.push_back(r);
        endfunction

        function void emit_head(sbic_pkg::kind_t k);
            emit(k, slot_addr[head], slot_info[head], slot_pc[head]);
        endfunction

        // one cache request in flight at most
        function void issue_head();
            if (count > 0 && !issued)
            begin
                issued = 1'b1;
                emit_head(sbic_pkg::KIND_ISSUE);
            end
        endfunction

        // accepted request: update the shadow and queue what the block owes for it
        function void note_request(sbic_pkg::item_t req);
            sbic_pkg::info_t inf;
            logic [31:0]     age;
            inf.size   = req.access_size;
            inf.atomic = req.is_atomic;
            inf.thread = req.thread_id;
            inf.mode   = req.priv_mode;
            step_results.delete();
            case (req.opcode)
                sbic_pkg::OP_INSERT:
                begin
                    if (count >= BUF_DEPTH || atomic_block)
                        emit(sbic_pkg::KIND_ERROR, req.address, inf, req.program_counter);
                    else
                    begin
                        if (!req.is_atomic)
                            emit(sbic_pkg::KIND_STORE_NOTICE, req.address, inf,
                                 req.program_counter);
                        if (count > 0)
                            emit(sbic_pkg::KIND_PREFETCH, req.address, inf,
                                 req.program_counter);
                        slot_addr[tail]  = req.address;
                        slot_pc[tail]    = req.program_counter;
                        slot_info[tail]  = inf;
                        slot_stamp[tail] = now;
                        count++;
                        tail = (tail + 1) % BUF_DEPTH;
                        if (req.is_atomic)
                            atomic_block = 1'b1;
                        if (step_results.size() < 2)
                            issue_head();
                    end
                end
                sbic_pkg::OP_COMPLETE:
                begin
                    if (count == 0 || !issued || (req.address % LINE_SIZE) != 0 ||
                        head_line() != req.address)
                        emit(sbic_pkg::KIND_ERROR, req.address, '0, '0);
                    else
                    begin
                        issued = 1'b0;
                        if (slot_info[head].atomic)
                        begin
                            emit_head(sbic_pkg::KIND_ATOMIC_NOTICE);
                            atomic_block = 1'b0;
                        end
                        count--;
                        head     = (head + 1) % BUF_DEPTH;
                        alarm_on = 1'b0;
                        if (step_results.size() < 2)
                            issue_head();
                    end
                end
                sbic_pkg::OP_TICK:
                begin
                    now++;
                    if (count > 0 && !alarm_on)
                    begin
                        age = now - slot_stamp[head];
                        if (age >= threshold)
                        begin
                            alarm_on = 1'b1;
                            emit_head(sbic_pkg::KIND_DEADLOCK);
                        end
                    end
                end
                default:
                    emit(sbic_pkg::KIND_ERROR, '0, '0, '0);
            endcase
            foreach (step_results[i])
            begin
                step_results[i].ready_res = (count < BUF_DEPTH) && !atomic_block;
                step_results[i].last      = (i == step_results.size() - 1);
                awaited.push_back(step_results[i]);
            end
        endfunction

        function void check_field(string name, logic [47:0] want, logic [47:0] got);
            if (got !== want)
            begin
                error_count++;
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_result(sbic_pkg::result_t got);
            sbic_pkg::result_t want;
            if (awaited.size() == 0)
            begin
                error_count++;
                $display("%0t: result with nothing expected, expected none, got kind %0d addr %h",
                         $time, got.kind, got.out_address);
                return;
            end
            want = awaited.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("out_address", want.out_address, got.out_address);
            check_field("out_size", want.out_size, got.out_size);
            check_field("out_atomic", want.out_atomic, got.out_atomic);
            check_field("out_thread", want.out_thread, got.out_thread);
            check_field("out_pc", want.out_pc, got.out_pc);
            check_field("out_mode", want.out_mode, got.out_mode);
            check_field("ready_res", want.ready_res, got.ready_res);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    sbic_pkg::item_t   item;
    logic              pop;
    logic              empty;
    sbic_pkg::result_t result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    issue_scoreboard sb;
    bit              no_idle;
    int unsigned     cycle_count;

    store_buffer_issue_control dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .pop     (pop),
        .empty   (empty),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    // result side stalls at random except during no-idle stretches
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    // request with every field random, used for ticks and unknown opcodes too
    function automatic sbic_pkg::item_t noise_item(sbic_pkg::opcode_t op);
        sbic_pkg::item_t it;
        it.opcode          = op;
        it.address         = rand48();
        it.access_size     = 7'($urandom);
        it.is_atomic       = 1'($urandom);
        it.thread_id       = 8'($urandom);
        it.program_counter = rand48();
        it.priv_mode       = 1'($urandom);
        return it;
    endfunction

    function automatic sbic_pkg::item_t store_item(logic [47:0] addr, logic [6:0] size,
                                                   logic atom, logic [7:0] thr,
                                                   logic [47:0] pc, logic mode);
        sbic_pkg::item_t it;
        it.opcode          = sbic_pkg::OP_INSERT;
        it.address         = addr;
        it.access_size     = size;
        it.is_atomic       = atom;
        it.thread_id       = thr;
        it.program_counter = pc;
        it.priv_mode       = mode;
        return it;
    endfunction

    function automatic sbic_pkg::item_t completion_item(logic [47:0] addr);
        sbic_pkg::item_t it;
        it         = noise_item(sbic_pkg::OP_COMPLETE);
        it.address = addr;
        return it;
    endfunction

    function automatic sbic_pkg::item_t random_store(int atomic_pct);
        sbic_pkg::item_t it;
        it             = noise_item(sbic_pkg::OP_INSERT);
        it.access_size = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(64, 1));
        it.is_atomic   = ($urandom_range(99) < atomic_pct);
        return it;
    endfunction

    // mostly the head's own line, otherwise misaligned, another line or anything
    function automatic sbic_pkg::item_t random_completion(int good_pct);
        logic [47:0] line;
        logic [47:0] r;
        r    = rand48();
        line = (sb.count > 0) ? sb.head_line() : r - (r % LINE_SIZE);
        if ($urandom_range(99) < good_pct)
            return completion_item(line);
        case ($urandom_range(2))
            0:       return completion_item(line | 48'($urandom_range(LINE_SIZE - 1, 1)));
            1:       return completion_item(line ^ (48'(LINE_SIZE) << $urandom_range(41)));
            default: return completion_item(r);
        endcase
    endfunction

    // push stays high between back-to-back requests, only an idle cycle lowers it
    task automatic send_request(sbic_pkg::item_t req);
        if (!no_idle)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        push <= 1'b1;
        item <= req;
        do @(posedge clk); while (full);
        sb.note_request(req);
    endtask

    // wait for every owed result, then let a request that owes nothing finish inside
    task automatic drain();
        push <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one setup plus access transfer; psel is left high so transfers can chain
    task automatic apb_access(bit is_write, logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= THRESHOLD_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic set_threshold(logic [31:0] value);
        logic [31:0] readback;
        drain();
        apb_access(1'b1, value, readback);
        apb_access(1'b0, '0, readback);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.threshold = value;
        sb.check_field("threshold readback", value, readback);
    endtask

    task automatic run_directed();
        // completion with an empty buffer, a quiet tick, an unknown opcode
        send_request(completion_item('0));
        send_request(noise_item(sbic_pkg::OP_TICK));
        send_request(noise_item(sbic_pkg::OP_UNUSED));
        // extremes of the entry fields, second store also gets a prefetch
        send_request(store_item('1, 7'd64, 1'b0, 8'hff, '1, 1'b1));
        send_request(store_item('0, 7'd1, 1'b0, 8'h00, '0, 1'b0));
        send_request(store_item(rand48(), 7'd0, 1'b0, 8'h5a, rand48(), 1'b0));
        send_request(store_item(rand48(), 7'h7f, 1'b0, 8'ha5, rand48(), 1'b1));
        // misaligned and wrong-line completions, then a good one
        send_request(completion_item(sb.head_line() | 48'd1));
        send_request(completion_item(sb.head_line() ^ 48'(LINE_SIZE)));
        send_request(completion_item(sb.head_line()));
        // atomic behind plain stores, then a store refused while it waits
        send_request(store_item(rand48(), 7'd8, 1'b1, 8'h11, rand48(), 1'b1));
        send_request(store_item(rand48(), 7'd4, 1'b0, 8'h22, rand48(), 1'b0));
        while (sb.count > 0)
            send_request(completion_item(sb.head_line()));
        // atomic into an empty buffer: issue only, then the delayed notice alone
        send_request(store_item(rand48(), 7'd16, 1'b1, 8'h33, rand48(), 1'b0));
        send_request(store_item(rand48(), 7'd2, 1'b0, 8'h44, rand48(), 1'b1));
        send_request(completion_item(sb.head_line()));
        send_request(random_completion(100));
        // plain store whose retire owes nothing
        send_request(store_item(rand48(), 7'd32, 1'b0, 8'h55, rand48(), 1'b0));
        send_request(completion_item(sb.head_line()));
    endtask

    task automatic run_mixed(int items, int ins_pct, int comp_pct, int tick_pct,
                             int atomic_pct, int quiet_items);
        int roll;
        for (int i = 0; i < items; i++)
        begin
            no_idle = (i < quiet_items);
            roll    = $urandom_range(99);
            if (roll < ins_pct)
                send_request(random_store(atomic_pct));
            else if (roll < ins_pct + comp_pct)
                send_request(random_completion(90));
            else if (roll < ins_pct + comp_pct + tick_pct)
                send_request(noise_item(sbic_pkg::OP_TICK));
            else
                send_request(noise_item(sbic_pkg::OP_UNUSED));
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        logic [31:0] readback;
        sb          = new();
        no_idle     = 1'b0;
        cycle_count = 0;
        clk         = 1'b0;
        rst_n   <= 1'b0;
        push    <= 1'b0;
        item    <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // threshold must come out of reset at its default
        apb_access(1'b0, '0, readback);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.check_field("threshold after reset", sbic_pkg::THRESHOLD_RESET, readback);

        run_directed();
        // smallest nonzero and zero thresholds: alarms on nearly every held head
        set_threshold(32'd1);
        run_mixed(200, 45, 33, 20, 10, 0);
        set_threshold(32'd0);
        run_mixed(100, 40, 30, 28, 10, 0);
        // largest threshold, insert-heavy with no atomics so the buffer fills up
        set_threshold(32'hffff_ffff);
        run_mixed(300, 80, 12, 7, 0, 0);
        // small threshold, opening with a stretch where neither side idles
        set_threshold(32'($urandom_range(40, 2)));
        run_mixed(400, 45, 33, 20, 10, 150);
        set_threshold($urandom);
        run_mixed(200, 45, 35, 18, 10, 0);

        drain();
        if (sb.error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/sbic_pkg.sv
rtl/sbic_fifo.sv
rtl/sbic_front.sv
rtl/sbic_back.sv
rtl/store_buffer_issue_control.sv
rtl/sbic_checker.sv
sim/tb_top.sv
